// ===== hw/rtl/ptts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants of the periodic task timer scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

	localparam int SLOTS    = 16;
	localparam int ID_BITS  = 16;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int TIME_W   = 48;
	localparam int PER_W    = 24;

	localparam logic [2:0] CMD_ONESHOT = 3'd0;
	localparam logic [2:0] CMD_RATE    = 3'd1;
	localparam logic [2:0] CMD_DELAY   = 3'd2;
	localparam logic [2:0] CMD_TICK    = 3'd3;
	localparam logic [2:0] CMD_DONE    = 3'd4;
	localparam logic [2:0] CMD_SHUT    = 3'd5;

	localparam logic [2:0] ST_ACCEPT   = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_SHUT     = 3'd2;
	localparam logic [2:0] ST_DISPATCH = 3'd3;
	localparam logic [2:0] ST_NOTHING  = 3'd4;

	localparam logic [1:0] SL_FREE = 2'd0;
	localparam logic [1:0] SL_WAIT = 2'd1;
	localparam logic [1:0] SL_RUN  = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE, OP_LATCH, OP_EXEC, OP_TICKADV, OP_SCAN_CLR, OP_SCAN_STEP, OP_DISPATCH
	} op_t;

	typedef struct packed {
		op_t op;
	} ctl_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        found;      // scan found a due task
		logic        scan_end;   // scan index on last slot
		logic [CNT_W-1:0] n_out;
	} sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ptts_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_datapath
// Task table, tick clock, id counter and the serial due-task scan.
// ----------------------------------------------------------------------------
module ptts_datapath
	import ptts_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ctl_t               ctl,
	output sts_t                    sts,
	input  wire logic [2:0]         command,
	input  wire logic [23:0]        start_delay,
	input  wire logic [23:0]        period,
	input  wire logic [3:0]         done_slot,
	output logic [2:0]              res_status,
	output logic [15:0]             res_id,
	output logic [3:0]              res_slot,
	output logic                    res_last
);

	logic [TIME_W-1:0]  dl_q   [SLOTS];
	logic [PER_W-1:0]   per_q  [SLOTS];
	logic               rate_q [SLOTS];
	logic [ID_BITS-1:0] id_q   [SLOTS];
	logic [1:0]         sl_q   [SLOTS];

	logic [TIME_W-1:0]  now_q;
	logic [ID_BITS-1:0] next_id_q;
	logic               shut_q;

	logic [2:0]  cmd_q;
	logic [23:0] dly_q, per_in_q;
	logic [3:0]  dslot_q;

	logic [SLOT_W-1:0] idx_q, best_q;
	logic              found_q;
	logic [TIME_W-1:0] best_dl_q;
	logic [CNT_W-1:0]  n_q;

	// Lowest free slot.
	logic              free_ok;
	logic [SLOT_W-1:0] free_idx;
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (sl_q[s] == SL_FREE) begin
				free_ok  = 1'b1;
				free_idx = SLOT_W'(s);
			end
		end
	end

	// Finished: reschedule deadline for the named slot.
	logic              dn_ok;
	logic [SLOT_W-1:0] dn_idx;
	logic [TIME_W-1:0] dn_rate, dn_dl;
	assign dn_ok  = ({28'd0, dslot_q} < 32'(SLOTS)) &&
		(sl_q[dslot_q[SLOT_W-1:0]] == SL_RUN);
	assign dn_idx = dslot_q[SLOT_W-1:0];
	always_comb begin
		dn_rate = dl_q[dn_idx] + TIME_W'(per_q[dn_idx]);
		if (dn_rate < now_q) dn_rate = now_q;
		dn_dl = rate_q[dn_idx] ? dn_rate : now_q + TIME_W'(per_q[dn_idx]);
	end

	logic cand;
	assign cand = (sl_q[idx_q] == SL_WAIT) && (dl_q[idx_q] <= now_q) &&
		(!found_q || dl_q[idx_q] < best_dl_q);

	assign sts.cmd      = cmd_q;
	assign sts.found    = found_q;
	assign sts.scan_end = (idx_q == SLOT_W'(SLOTS - 1));
	assign sts.n_out    = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q     <= '0;
			next_id_q <= '0;
			shut_q    <= 1'b0;
			for (int s = 0; s < SLOTS; s++) sl_q[s] <= SL_FREE;
			idx_q     <= '0;
			found_q   <= 1'b0;
			n_q       <= '0;
		end else begin
			case (ctl.op)
				OP_LATCH: begin
					cmd_q    <= command;
					dly_q    <= start_delay;
					per_in_q <= period;
					dslot_q  <= done_slot;
					n_q      <= '0;
				end
				OP_EXEC: begin
					res_last <= 1'b1;
					res_id   <= '0;
					res_slot <= '0;
					case (cmd_q)
						CMD_ONESHOT, CMD_RATE, CMD_DELAY: begin
							if (shut_q) res_status <= ST_SHUT;
							else if (!free_ok) res_status <= ST_FULL;
							else begin
								dl_q[free_idx]   <= now_q + TIME_W'(dly_q);
								per_q[free_idx]  <= (cmd_q == CMD_ONESHOT) ? '0 : per_in_q;
								rate_q[free_idx] <= (cmd_q == CMD_RATE);
								id_q[free_idx]   <= next_id_q;
								sl_q[free_idx]   <= SL_WAIT;
								next_id_q        <= next_id_q + ID_BITS'(1);
								res_status       <= ST_ACCEPT;
								res_id           <= 16'(next_id_q);
								res_slot         <= 4'(free_idx);
							end
						end
						CMD_DONE: begin
							res_slot <= dslot_q;
							if (!dn_ok) res_status <= ST_NOTHING;
							else begin
								res_status <= ST_ACCEPT;
								res_id     <= 16'(id_q[dn_idx]);
								if (per_q[dn_idx] == '0 || shut_q) sl_q[dn_idx] <= SL_FREE;
								else begin
									dl_q[dn_idx] <= dn_dl;
									sl_q[dn_idx] <= SL_WAIT;
								end
							end
						end
						CMD_SHUT: begin
							shut_q     <= 1'b1;
							for (int s = 0; s < SLOTS; s++) sl_q[s] <= SL_FREE;
							res_status <= ST_ACCEPT;
						end
						default: res_status <= ST_NOTHING;
					endcase
				end
				OP_TICKADV: now_q <= now_q + TIME_W'(1);
				OP_SCAN_CLR: begin
					idx_q   <= '0;
					found_q <= 1'b0;
				end
				OP_SCAN_STEP: begin
					if (cand) begin
						found_q   <= 1'b1;
						best_q    <= idx_q;
						best_dl_q <= dl_q[idx_q];
					end
					idx_q <= idx_q + SLOT_W'(1);
				end
				OP_DISPATCH: begin
					// Called with found set: emit a dispatch beat.
					// With nothing found and no prior beat: the nothing beat.
					if (found_q) begin
						sl_q[best_q] <= SL_RUN;
						res_status   <= ST_DISPATCH;
						res_id       <= 16'(id_q[best_q]);
						res_slot     <= 4'(best_q);
						n_q          <= n_q + CNT_W'(1);
					end else begin
						res_status <= ST_NOTHING;
						res_id     <= '0;
						res_slot   <= '0;
					end
					res_last <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ptts_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_ctrl
// Sequencer for command execution, tick scans and result handshake.
// ----------------------------------------------------------------------------
module ptts_ctrl
	import ptts_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic      last_q,
	output ctl_t      ctl,
	input  wire sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_SCLR, S_SCAN, S_DISP, S_OUT
	} state_t;

	state_t state_q;
	logic   more_q;   // after the output beat, dispatch the task the rescan found
	logic   held_q;   // a dispatch beat waits in the result registers for its flag

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		ctl.op = OP_NONE;
		case (state_q)
			S_IDLE: if (in_valid) ctl.op = OP_LATCH;
			S_EXEC: ctl.op = (sts.cmd == CMD_TICK) ? OP_TICKADV : OP_EXEC;
			S_SCLR: ctl.op = OP_SCAN_CLR;
			S_SCAN: ctl.op = OP_SCAN_STEP;
			S_DISP: ctl.op = (!held_q && (sts.found || sts.n_out == '0)) ?
				OP_DISPATCH : OP_NONE;
			default: ctl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			last_q    <= 1'b0;
			more_q    <= 1'b0;
			held_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: begin
					if (sts.cmd == CMD_TICK) state_q <= S_SCLR;
					else begin
						out_valid <= 1'b1;
						last_q    <= 1'b1;
						more_q    <= 1'b0;
						state_q   <= S_OUT;
					end
				end
				S_SCLR: state_q <= S_SCAN;
				S_SCAN: if (sts.scan_end) state_q <= S_DISP;
				S_DISP: begin
					if (held_q) begin
						// The rescan tells whether the held beat is the final one.
						out_valid <= 1'b1;
						last_q    <= !sts.found;
						more_q    <= sts.found;
						held_q    <= 1'b0;
						state_q   <= S_OUT;
					end else if (sts.found) begin
						if (sts.n_out == CNT_W'(SLOTS - 1)) begin
							// The sixteenth dispatch always closes the tick.
							out_valid <= 1'b1;
							last_q    <= 1'b1;
							more_q    <= 1'b0;
							state_q   <= S_OUT;
						end else begin
							held_q  <= 1'b1;
							state_q <= S_SCLR;
						end
					end else if (sts.n_out == '0) begin
						out_valid <= 1'b1;
						last_q    <= 1'b1;
						more_q    <= 1'b0;
						state_q   <= S_OUT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q   <= more_q ? S_DISP : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/periodic_task_timer_scheduler.sv =====
`default_nettype none
// A non-tick command's beat is offered in the cycle after acceptance.
// A tick with nothing due offers its beat once the scan ends; otherwise each dispatch
// but the sixteenth of a tick is followed by a serial rescan of the 16 slots (one slot a
// cycle) that decides its final flag. The block takes one command at a time: in_stall
// stays high until the last result beat of the command is taken.
// Reset: arst_n clears the clock, id counter, shut flag and slot states.
// ----------------------------------------------------------------------------
// periodic_task_timer_scheduler
// Timer queue that schedules one-shot and periodic tasks against a tick clock.
// ----------------------------------------------------------------------------
module periodic_task_timer_scheduler
	import ptts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [23:0] start_delay,
	input  wire logic [23:0] period,
	input  wire logic [3:0]  done_slot,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [15:0]      task_id,
	output logic [3:0]       task_slot,
	output logic             last
);

	ctl_t ctl;
	sts_t sts;
	logic last_c, last_d;

	// The controller sequences each command; the datapath holds the table.
	// A dispatch beat is held in the output register while the datapath
	// rescans, and its final flag is decided by the controller.
	ptts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .last_q(last_c),
		.ctl(ctl), .sts(sts)
	);

	ptts_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.command(command), .start_delay(start_delay), .period(period),
		.done_slot(done_slot), .res_status(status), .res_id(task_id),
		.res_slot(task_slot), .res_last(last_d)
	);

	assign last = last_c | last_d;

endmodule
`default_nettype wire

// ===== hw/rtl/ptts_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level assertions for the scheduler.
// ----------------------------------------------------------------------------
module ptts_checker
	import ptts_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] status,
	input wire logic       last
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken during output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled beat changed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_NOTHING) else $error("bad status");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DISPATCH |-> last) else $error("unmarked beat");

endmodule

bind periodic_task_timer_scheduler ptts_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status), .last(last)
);
`default_nettype wire

// ===== tb/periodic_task_timer_scheduler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_task_timer_scheduler_test
// Self-checking bench for the timer scheduler. A directed table covers the
// corner cases, then random command streams exercise scheduling, ticks,
// completions and shutdown. Every result beat is compared with an in-bench
// scheduler model, or with the beat typed into a directed row.
// ----------------------------------------------------------------------------
module periodic_task_timer_scheduler_test;
	import ptts_pkg::*;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] task_id;
		logic [3:0]  task_slot;
		logic        last;
	} result_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [23:0] dly;
		logic [23:0] per;
		logic [3:0]  slot;
		bit          fixed;      // expected beat typed into the table
		result_t     res;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  command = '0;
	logic [23:0] start_delay = '0;
	logic [23:0] period = '0;
	logic [3:0]  done_slot = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [2:0]  status;
	logic [15:0] task_id;
	logic [3:0]  task_slot;
	logic        last;

	periodic_task_timer_scheduler u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .start_delay(start_delay), .period(period),
		.done_slot(done_slot),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .task_id(task_id), .task_slot(task_slot), .last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Scheduler state mirrored by the bench.
	logic [TIME_W-1:0] now_ticks;
	logic [TIME_W-1:0] deadline [SLOTS];
	logic [PER_W-1:0]  per_tab [SLOTS];
	logic              rate_tab [SLOTS];
	logic [1:0]        slot_st [SLOTS];
	logic [15:0]       id_tab [SLOTS];
	logic [15:0]       next_id;
	logic              shut;

	result_t pending_beats[$];
	int      mismatches = 0;
	int      beats_seen = 0;
	int      dispatches = 0;
	int      idle_cycles = 0;
	bit      stim_done = 1'b0;
	bit      long_hold = 1'b0;

	function automatic result_t mk(logic [2:0] st, logic [15:0] id, logic [3:0] sl, logic l);
		result_t r;
		r.status = st; r.task_id = id; r.task_slot = sl; r.last = l;
		return r;
	endfunction

	function automatic void clear_table();
		now_ticks = '0; next_id = '0; shut = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			slot_st[s] = SL_FREE;
		end
	endfunction

	// Work out the beats one command causes and queue them.
	function automatic void predict_schedule(stim_t t);
		int n;
		int best;
		int fs;
		logic [TIME_W-1:0] d;
		n = 0;
		fs = -1;
		case (t.cmd)
			CMD_ONESHOT, CMD_RATE, CMD_DELAY: begin
				for (int s = SLOTS - 1; s >= 0; s--)
					if (slot_st[s] == SL_FREE) fs = s;
				if (shut) begin
					pending_beats.push_back(mk(ST_SHUT, 0, 0, 1));
				end else if (fs < 0) begin
					pending_beats.push_back(mk(ST_FULL, 0, 0, 1));
				end else begin
					deadline[fs] = now_ticks + TIME_W'(t.dly);
					per_tab[fs] = (t.cmd == CMD_ONESHOT) ? '0 : t.per;
					rate_tab[fs] = (t.cmd == CMD_RATE);
					id_tab[fs] = next_id;
					slot_st[fs] = SL_WAIT;
					next_id++;
					pending_beats.push_back(mk(ST_ACCEPT, id_tab[fs], 4'(fs), 1));
				end
			end
			CMD_TICK: begin
				now_ticks++;
				while (n < SLOTS) begin
					best = -1;
					for (int s = 0; s < SLOTS; s++)
						if (slot_st[s] == SL_WAIT && deadline[s] <= now_ticks &&
						    (best < 0 || deadline[s] < deadline[best])) best = s;
					if (best < 0) break;
					slot_st[best] = SL_RUN;
					pending_beats.push_back(mk(ST_DISPATCH, id_tab[best], 4'(best), 0));
					n++;
				end
				if (n == 0) pending_beats.push_back(mk(ST_NOTHING, 0, 0, 1));
				else pending_beats[$].last = 1'b1;
			end
			CMD_DONE: begin
				if (slot_st[t.slot] != SL_RUN) begin
					pending_beats.push_back(mk(ST_NOTHING, 0, t.slot, 1));
				end else begin
					if (per_tab[t.slot] == 0 || shut) begin
						slot_st[t.slot] = SL_FREE;
					end else begin
						if (rate_tab[t.slot]) begin
							d = deadline[t.slot] + TIME_W'(per_tab[t.slot]);
							if (d < now_ticks) d = now_ticks;
						end else begin
							d = now_ticks + TIME_W'(per_tab[t.slot]);
						end
						deadline[t.slot] = d;
						slot_st[t.slot] = SL_WAIT;
					end
					pending_beats.push_back(mk(ST_ACCEPT, id_tab[t.slot], t.slot, 1));
				end
			end
			CMD_SHUT: begin
				shut = 1'b1;
				for (int s = 0; s < SLOTS; s++) slot_st[s] = SL_FREE;
				pending_beats.push_back(mk(ST_ACCEPT, 0, 0, 1));
			end
			default: pending_beats.push_back(mk(ST_NOTHING, 0, 0, 1));
		endcase
	endfunction

	// Offer one command beat and hold it until the block takes it. Valid stays
	// high into the next command when no idle gap is drawn.
	task automatic send_command(stim_t t);
		int gap;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		command <= t.cmd;
		start_delay <= t.dly;
		period <= t.per;
		done_slot <= t.slot;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// Accepted at this edge; predict now, before any result can come back.
		// A typed row checks the block against the value written in the table.
		predict_schedule(t);
		if (t.fixed) pending_beats[$] = t.res;
	endtask

	function automatic stim_t row(logic [2:0] c, logic [23:0] d, logic [23:0] p,
	                              logic [3:0] s);
		stim_t t;
		t.cmd = c; t.dly = d; t.per = p; t.slot = s; t.fixed = 0; t.res = '0;
		return t;
	endfunction

	function automatic stim_t row_x(logic [2:0] c, logic [23:0] d, logic [23:0] p,
	                                logic [3:0] s, result_t r);
		stim_t t;
		t = row(c, d, p, s);
		t.fixed = 1; t.res = r;
		return t;
	endfunction

	// Result side: random stalls, plus one long hold-off to back the block up.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			result_t got;
			result_t want;
			got = mk(status, task_id, task_slot, last);
			beats_seen++;
			if (status == ST_DISPATCH) dispatches++;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: status %0d id %0d slot %0d last %0d",
					         status, task_id, task_slot, last);
			end else begin
				want = pending_beats.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected st %0d id %0d slot %0d last %0d, got st %0d id %0d slot %0d last %0d",
						         want.status, want.task_id, want.task_slot, want.last,
						         got.status, got.task_id, got.task_slot, got.last);
				end
			end
		end
	end

	initial begin : result_side
		int hold;
		out_stall <= 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				hold = 0;
				while (hold < 300) begin
					@(posedge clk);
					hold++;
				end
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 3) == 0 && !stim_done) begin
				hold = $urandom_range(0, 14);
				if (hold > 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
				end
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: nothing accepted on either side for too long ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("watchdog expired with %0d beats outstanding", pending_beats.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin : stimulus
		stim_t dir[$];
		stim_t t;
		int k;
		int sched_bias;
		clear_table();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: reset state, extremes, idle ticks, bad completions and
		// the unused codes; the full table and shutdown come after it.
		dir.push_back(row_x(CMD_TICK, 0, 0, 0, mk(ST_NOTHING, 0, 0, 1)));
		dir.push_back(row_x(CMD_DONE, 0, 0, 4'd15, mk(ST_NOTHING, 0, 4'd15, 1)));
		dir.push_back(row_x(3'd6, 24'hFFFFFF, 24'hFFFFFF, 4'd15, mk(ST_NOTHING, 0, 0, 1)));
		dir.push_back(row_x(3'd7, 0, 0, 0, mk(ST_NOTHING, 0, 0, 1)));
		dir.push_back(row_x(CMD_ONESHOT, 0, 24'hFFFFFF, 0, mk(ST_ACCEPT, 0, 0, 1)));
		dir.push_back(row(CMD_RATE, 1, 1, 0));
		dir.push_back(row(CMD_DELAY, 24'hFFFFFF, 24'hFFFFFF, 0));
		dir.push_back(row(CMD_RATE, 0, 0, 0));
		dir.push_back(row(CMD_TICK, 0, 0, 0));
		dir.push_back(row(CMD_DONE, 0, 0, 0));
		dir.push_back(row(CMD_DONE, 0, 0, 1));
		dir.push_back(row(CMD_DONE, 0, 0, 3));
		dir.push_back(row(CMD_TICK, 0, 0, 0));
		dir.push_back(row(CMD_DONE, 0, 0, 1));
		for (int i = 0; i < 8; i++) dir.push_back(row(CMD_DELAY, 2, 5, 0));
		dir.push_back(row(CMD_TICK, 0, 0, 0));
		for (int i = 0; i < dir.size(); i++) send_command(dir[i]);

		// Fill the table completely and take a rejection.
		for (int i = 0; i < 6; i++) send_command(row(CMD_ONESHOT, 0, 0, 0));
		send_command(row(CMD_ONESHOT, 0, 0, 0));

		// Pressure: stall the result side while ticks keep coming.
		long_hold = 1'b1;
		for (int i = 0; i < 6; i++) send_command(row(CMD_TICK, 0, 0, 0));

		// Random part: mostly short-delay scheduling, ticks and completions of
		// running slots, with occasional shutdown and reset-free noise.
		k = 0;
		while (k < 440) begin
			sched_bias = $urandom_range(0, 99);
			t = row(3'($urandom_range(0, 2)), 24'($urandom_range(0, 6)),
			        24'($urandom_range(0, 8)), 4'($urandom_range(0, 15)));
			if (sched_bias < 2) t.dly = 24'($urandom);
			if (sched_bias < 4) t.per = 24'($urandom);
			if (sched_bias >= 35 && sched_bias < 65) t.cmd = CMD_TICK;
			else if (sched_bias >= 65 && sched_bias < 95) begin
				t.cmd = CMD_DONE;
				for (int s = 0; s < SLOTS; s++)
					if (slot_st[s] == SL_RUN && $urandom_range(0, 1)) t.slot = 4'(s);
			end else if (sched_bias >= 95 && sched_bias < 97)
				t.cmd = 3'(6 + $urandom_range(0, 1));
			else if (sched_bias == 97 && k > 380) t.cmd = CMD_SHUT;
			send_command(t);
			k++;
		end
		send_command(row(CMD_SHUT, 0, 0, 0));
		send_command(row(CMD_ONESHOT, 1, 1, 0));
		send_command(row(CMD_TICK, 0, 0, 0));
		in_valid <= 1'b0;
		stim_done = 1'b1;

		while (pending_beats.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d result beats including %0d dispatches over directed and random commands",
		         beats_seen, dispatches);
		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_datapath.sv
hw/rtl/ptts_ctrl.sv
hw/rtl/periodic_task_timer_scheduler.sv
hw/rtl/ptts_checker.sv
tb/periodic_task_timer_scheduler_test.sv
